>>> hdl/qmu_pkg.sv
// qmu_pkg.sv: shared widths, mode codes, payload types and fixed-point helpers
// of the quaternion math unit. No dependencies; used by all but qmu_stream_if.
package qmu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DW            = 32;
	localparam int PW            = 2 * DW;
	localparam int ACC_W         = PW + 2;
	localparam int NPROD         = 16;
	localparam int NVAL          = 9;
	localparam int NROT          = 9;
	localparam int NAXIS         = 3;

	localparam logic [1:0] MODE_MUL  = 2'd0;
	localparam logic [1:0] MODE_ROT  = 2'd1;
	localparam logic [1:0] MODE_MAT  = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [1:0] ROW_LAST  = 2'd3;

	typedef logic signed [DW-1:0]    fix_t;
	typedef logic signed [PW-1:0]    prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [1:0] mode;
		fix_t       q_w;
		fix_t       q_x;
		fix_t       q_y;
		fix_t       q_z;
		fix_t       p_w;
		fix_t       p_x;
		fix_t       p_y;
		fix_t       p_z;
	} in_item_t;

	typedef struct packed {
		fix_t res_0;
		fix_t res_1;
		fix_t res_2;
		fix_t res_3;
		logic last_row;
	} out_item_t;

	// operands that travel with an item down the pipe
	typedef struct packed {
		logic [1:0] mode;
		fix_t       q_w;
		fix_t       q_x;
		fix_t       q_y;
		fix_t       q_z;
		fix_t       p_x;
		fix_t       p_y;
		fix_t       p_z;
	} ctx_t;

	typedef struct packed {
		logic                       valid;
		ctx_t                       ctx;
		logic [NVAL-1:0][DW-1:0]    val;
	} stage_t;

	function automatic acc_t ext_p(input prod_t p);
		return acc_t'(p);
	endfunction

	function automatic acc_t dbl_p(input prod_t p);
		return acc_t'(p) <<< 1;
	endfunction

	function automatic acc_t ext_f(input fix_t v);
		return acc_t'(v);
	endfunction

	// drop the fraction bits (floor), then clamp to the signed 32-bit range
	function automatic fix_t sat_shift(input acc_t a, input int frac);
		acc_t              sh;
		logic [ACC_W-DW:0] hi;
		sh = a >>> frac;
		hi = sh[ACC_W-1:DW-1];
		if ((&hi) || !(|hi))
			return fix_t'(sh[DW-1:0]);
		else if (sh[ACC_W-1])
			return fix_t'({1'b1, {(DW-1){1'b0}}});
		else
			return fix_t'({1'b0, {(DW-1){1'b1}}});
	endfunction

endpackage

>>> hdl/qmu_stream_if.sv
// qmu_stream_if.sv: valid/ready stream channel with a typed payload.
// Payload types come from qmu_pkg at the point of instantiation.
interface qmu_stream_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

>>> hdl/qmu_front.sv
// qmu_front.sv: first pass of the unit: operand select and 16 multipliers,
// signed sums, then shift and saturate. Depends on qmu_pkg.
module qmu_front #(
	parameter int FRAC_BITS = qmu_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qmu_pkg::in_item_t  in_data,
	input  logic               nxt_ready,
	output qmu_pkg::stage_t    out_stage
);

	// 1.0 at the scale of a full product, before the fraction bits are dropped
	localparam qmu_pkg::acc_t ONE_ACC = qmu_pkg::acc_t'(1) <<< (2 * FRAC_BITS);

	qmu_pkg::fix_t  w, x, y, z, pw, px, py, pz;
	qmu_pkg::fix_t  opa [qmu_pkg::NPROD];
	qmu_pkg::fix_t  opb [qmu_pkg::NPROD];
	qmu_pkg::ctx_t  in_ctx;
	qmu_pkg::acc_t  sum_d [qmu_pkg::NVAL];

	logic           valid_s1, valid_s2, valid_s3;
	logic           en_s1, en_s2, en_s3;
	qmu_pkg::ctx_t  ctx_s1, ctx_s2, ctx_s3;
	qmu_pkg::prod_t prod_s1 [qmu_pkg::NPROD];
	qmu_pkg::acc_t  sum_s2 [qmu_pkg::NVAL];
	logic [qmu_pkg::NVAL-1:0][qmu_pkg::DW-1:0] val_s3;

	assign w  = in_data.q_w;
	assign x  = in_data.q_x;
	assign y  = in_data.q_y;
	assign z  = in_data.q_z;
	assign pw = in_data.p_w;
	assign px = in_data.p_x;
	assign py = in_data.p_y;
	assign pz = in_data.p_z;

	assign in_ctx = '{mode: in_data.mode, q_w: w, q_x: x, q_y: y, q_z: z,
		p_x: px, p_y: py, p_z: pz};

	// a stage advances when it is empty or its content moves on
	assign en_s3    = !valid_s3 || nxt_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		for (int i = 0; i < qmu_pkg::NPROD; i++) begin
			opa[i] = '0;
			opb[i] = '0;
		end
		unique case (in_data.mode)
			qmu_pkg::MODE_MUL: begin
				opa[0]  = w; opb[0]  = pw;
				opa[1]  = x; opb[1]  = px;
				opa[2]  = y; opb[2]  = py;
				opa[3]  = z; opb[3]  = pz;
				opa[4]  = w; opb[4]  = px;
				opa[5]  = x; opb[5]  = pw;
				opa[6]  = y; opb[6]  = pz;
				opa[7]  = z; opb[7]  = py;
				opa[8]  = w; opb[8]  = py;
				opa[9]  = x; opb[9]  = pz;
				opa[10] = y; opb[10] = pw;
				opa[11] = z; opb[11] = px;
				opa[12] = w; opb[12] = pz;
				opa[13] = x; opb[13] = py;
				opa[14] = y; opb[14] = px;
				opa[15] = z; opb[15] = pw;
			end
			qmu_pkg::MODE_ROT: begin
				// cross product terms of q.xyz x v
				opa[0] = y; opb[0] = pz;
				opa[1] = z; opb[1] = py;
				opa[2] = z; opb[2] = px;
				opa[3] = x; opb[3] = pz;
				opa[4] = x; opb[4] = py;
				opa[5] = y; opb[5] = px;
			end
			qmu_pkg::MODE_MAT: begin
				opa[0] = x; opb[0] = x;
				opa[1] = y; opb[1] = y;
				opa[2] = z; opb[2] = z;
				opa[3] = x; opb[3] = y;
				opa[4] = x; opb[4] = z;
				opa[5] = y; opb[5] = z;
				opa[6] = w; opb[6] = x;
				opa[7] = w; opb[7] = y;
				opa[8] = w; opb[8] = z;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < qmu_pkg::NVAL; i++)
			sum_d[i] = '0;
		unique case (ctx_s1.mode)
			qmu_pkg::MODE_MUL: begin
				sum_d[0] = qmu_pkg::ext_p(prod_s1[0]) - qmu_pkg::ext_p(prod_s1[1])
					- qmu_pkg::ext_p(prod_s1[2]) - qmu_pkg::ext_p(prod_s1[3]);
				sum_d[1] = qmu_pkg::ext_p(prod_s1[4]) + qmu_pkg::ext_p(prod_s1[5])
					+ qmu_pkg::ext_p(prod_s1[6]) - qmu_pkg::ext_p(prod_s1[7]);
				sum_d[2] = qmu_pkg::ext_p(prod_s1[8]) - qmu_pkg::ext_p(prod_s1[9])
					+ qmu_pkg::ext_p(prod_s1[10]) + qmu_pkg::ext_p(prod_s1[11]);
				sum_d[3] = qmu_pkg::ext_p(prod_s1[12]) + qmu_pkg::ext_p(prod_s1[13])
					- qmu_pkg::ext_p(prod_s1[14]) + qmu_pkg::ext_p(prod_s1[15]);
			end
			qmu_pkg::MODE_ROT: begin
				sum_d[0] = qmu_pkg::dbl_p(prod_s1[0]) - qmu_pkg::dbl_p(prod_s1[1]);
				sum_d[1] = qmu_pkg::dbl_p(prod_s1[2]) - qmu_pkg::dbl_p(prod_s1[3]);
				sum_d[2] = qmu_pkg::dbl_p(prod_s1[4]) - qmu_pkg::dbl_p(prod_s1[5]);
			end
			qmu_pkg::MODE_MAT: begin
				// row-major 3x3; products are xx yy zz xy xz yz wx wy wz
				sum_d[0] = ONE_ACC - qmu_pkg::dbl_p(prod_s1[1]) - qmu_pkg::dbl_p(prod_s1[2]);
				sum_d[1] = qmu_pkg::dbl_p(prod_s1[3]) + qmu_pkg::dbl_p(prod_s1[8]);
				sum_d[2] = qmu_pkg::dbl_p(prod_s1[4]) - qmu_pkg::dbl_p(prod_s1[7]);
				sum_d[3] = qmu_pkg::dbl_p(prod_s1[3]) - qmu_pkg::dbl_p(prod_s1[8]);
				sum_d[4] = ONE_ACC - qmu_pkg::dbl_p(prod_s1[0]) - qmu_pkg::dbl_p(prod_s1[2]);
				sum_d[5] = qmu_pkg::dbl_p(prod_s1[5]) + qmu_pkg::dbl_p(prod_s1[6]);
				sum_d[6] = qmu_pkg::dbl_p(prod_s1[4]) + qmu_pkg::dbl_p(prod_s1[7]);
				sum_d[7] = qmu_pkg::dbl_p(prod_s1[5]) - qmu_pkg::dbl_p(prod_s1[6]);
				sum_d[8] = ONE_ACC - qmu_pkg::dbl_p(prod_s1[0]) - qmu_pkg::dbl_p(prod_s1[1]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			// drop items with the unused mode code at the door
			if (en_s1)
				valid_s1 <= in_valid && (in_data.mode != qmu_pkg::MODE_NONE);
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctx_s1 <= in_ctx;
			for (int i = 0; i < qmu_pkg::NPROD; i++)
				prod_s1[i] <= opa[i] * opb[i];
		end
		if (en_s2) begin
			ctx_s2 <= ctx_s1;
			for (int i = 0; i < qmu_pkg::NVAL; i++)
				sum_s2[i] <= sum_d[i];
		end
		if (en_s3) begin
			ctx_s3 <= ctx_s2;
			for (int i = 0; i < qmu_pkg::NVAL; i++)
				val_s3[i] <= qmu_pkg::sat_shift(sum_s2[i], FRAC_BITS);
		end
	end

	assign out_stage.valid = valid_s3;
	assign out_stage.ctx   = ctx_s3;
	assign out_stage.val   = val_s3;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.mode != qmu_pkg::MODE_NONE |=> valid_s1)
		else $error("accepted item did not enter the first stage");

	a_no_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ctx_s3.mode != qmu_pkg::MODE_NONE)
		else $error("unused mode code reached the end of the first pass");

endmodule

>>> hdl/qmu_rot.sv
// qmu_rot.sv: second pass for vector rotation: q_w*t and q.xyz x t products,
// sums with the scaled vector, saturate. Other modes pass through. Uses qmu_pkg.
module qmu_rot #(
	parameter int FRAC_BITS = qmu_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  qmu_pkg::stage_t  in_stage,
	output logic             in_ready,
	input  logic             done,
	output qmu_pkg::stage_t  out_stage
);

	qmu_pkg::fix_t  tx, ty, tz;
	qmu_pkg::fix_t  opa [qmu_pkg::NROT];
	qmu_pkg::fix_t  opb [qmu_pkg::NROT];
	qmu_pkg::acc_t  sum_d [qmu_pkg::NAXIS];
	logic [qmu_pkg::NVAL-1:0][qmu_pkg::DW-1:0] val_d;

	logic           valid_s4, valid_s5, valid_s6;
	logic           en_s4, en_s5, en_s6;
	qmu_pkg::ctx_t  ctx_s4, ctx_s5, ctx_s6;
	qmu_pkg::prod_t prod_s4 [qmu_pkg::NROT];
	qmu_pkg::acc_t  sum_s5 [qmu_pkg::NAXIS];
	logic [qmu_pkg::NVAL-1:0][qmu_pkg::DW-1:0] val_s4, val_s5, val_s6;

	assign en_s6    = !valid_s6 || done;
	assign en_s5    = !valid_s5 || en_s6;
	assign en_s4    = !valid_s4 || en_s5;
	assign in_ready = en_s4;

	assign tx = qmu_pkg::fix_t'(in_stage.val[0]);
	assign ty = qmu_pkg::fix_t'(in_stage.val[1]);
	assign tz = qmu_pkg::fix_t'(in_stage.val[2]);

	always_comb begin
		opa[0] = in_stage.ctx.q_w; opb[0] = tx;
		opa[1] = in_stage.ctx.q_y; opb[1] = tz;
		opa[2] = in_stage.ctx.q_z; opb[2] = ty;
		opa[3] = in_stage.ctx.q_w; opb[3] = ty;
		opa[4] = in_stage.ctx.q_z; opb[4] = tx;
		opa[5] = in_stage.ctx.q_x; opb[5] = tz;
		opa[6] = in_stage.ctx.q_w; opb[6] = tz;
		opa[7] = in_stage.ctx.q_x; opb[7] = ty;
		opa[8] = in_stage.ctx.q_y; opb[8] = tx;
	end

	always_comb begin
		sum_d[0] = (qmu_pkg::ext_f(ctx_s4.p_x) <<< FRAC_BITS) + qmu_pkg::ext_p(prod_s4[0])
			+ qmu_pkg::ext_p(prod_s4[1]) - qmu_pkg::ext_p(prod_s4[2]);
		sum_d[1] = (qmu_pkg::ext_f(ctx_s4.p_y) <<< FRAC_BITS) + qmu_pkg::ext_p(prod_s4[3])
			+ qmu_pkg::ext_p(prod_s4[4]) - qmu_pkg::ext_p(prod_s4[5]);
		sum_d[2] = (qmu_pkg::ext_f(ctx_s4.p_z) <<< FRAC_BITS) + qmu_pkg::ext_p(prod_s4[6])
			+ qmu_pkg::ext_p(prod_s4[7]) - qmu_pkg::ext_p(prod_s4[8]);
	end

	always_comb begin
		val_d = val_s5;
		if (ctx_s5.mode == qmu_pkg::MODE_ROT) begin
			for (int i = 0; i < qmu_pkg::NAXIS; i++)
				val_d[i] = qmu_pkg::sat_shift(sum_s5[i], FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s4)
				valid_s4 <= in_stage.valid;
			if (en_s5)
				valid_s5 <= valid_s4;
			if (en_s6)
				valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ctx_s4 <= in_stage.ctx;
			val_s4 <= in_stage.val;
			for (int i = 0; i < qmu_pkg::NROT; i++)
				prod_s4[i] <= opa[i] * opb[i];
		end
		if (en_s5) begin
			ctx_s5 <= ctx_s4;
			val_s5 <= val_s4;
			for (int i = 0; i < qmu_pkg::NAXIS; i++)
				sum_s5[i] <= sum_d[i];
		end
		if (en_s6) begin
			ctx_s6 <= ctx_s5;
			val_s6 <= val_d;
		end
	end

	assign out_stage.valid = valid_s6;
	assign out_stage.ctx   = ctx_s6;
	assign out_stage.val   = val_s6;

	a_hold_s6: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && !done |=> valid_s6 && $stable(val_s6))
		else $error("output stage lost or changed an item that was not finished");

endmodule

>>> hdl/qmu_rows.sv
// qmu_rows.sv: result formatter; one result for multiply and rotate, four
// matrix rows sent one per transfer. Depends on qmu_pkg.
module qmu_rows #(
	parameter int FRAC_BITS = qmu_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qmu_pkg::stage_t     stage,
	output logic                done,
	output logic                out_valid,
	input  logic                out_ready,
	output qmu_pkg::out_item_t  out_data
);

	localparam qmu_pkg::fix_t ONE_FIX = qmu_pkg::fix_t'(1) <<< FRAC_BITS;

	logic [1:0] row_q;
	logic       xfer, is_mat;
	logic [3:0] idx0, idx1, idx2;

	assign out_valid = stage.valid;
	assign xfer      = stage.valid && out_ready;
	assign is_mat    = stage.ctx.mode == qmu_pkg::MODE_MAT;
	assign done      = xfer && (!is_mat || row_q == qmu_pkg::ROW_LAST);

	assign idx0 = 4'(row_q) * 4'd3;
	assign idx1 = idx0 + 4'd1;
	assign idx2 = idx0 + 4'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (done) begin
			row_q <= '0;
		end else if (xfer) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_comb begin
		out_data = '0;
		unique case (stage.ctx.mode)
			qmu_pkg::MODE_MUL: begin
				out_data.res_0    = stage.val[0];
				out_data.res_1    = stage.val[1];
				out_data.res_2    = stage.val[2];
				out_data.res_3    = stage.val[3];
				out_data.last_row = 1'b1;
			end
			qmu_pkg::MODE_ROT: begin
				out_data.res_0    = stage.val[0];
				out_data.res_1    = stage.val[1];
				out_data.res_2    = stage.val[2];
				out_data.last_row = 1'b1;
			end
			qmu_pkg::MODE_MAT: begin
				if (row_q == qmu_pkg::ROW_LAST) begin
					out_data.res_3    = ONE_FIX;
					out_data.last_row = 1'b1;
				end else begin
					out_data.res_0 = stage.val[idx0];
					out_data.res_1 = stage.val[idx1];
					out_data.res_2 = stage.val[idx2];
				end
			end
			default: ;
		endcase
	end

	a_row_mat_only: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != 2'd0 |-> stage.valid && is_mat)
		else $error("row counter left non-zero outside a matrix item");

	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && is_mat && row_q != qmu_pkg::ROW_LAST |=> row_q == $past(row_q) + 2'd1)
		else $error("matrix row did not advance after a transfer");

endmodule

>>> hdl/quaternion_math_unit_core.sv
// Quaternion math unit: Hamilton product, vector rotation and rotation matrix rows.
// Six stages, s1 to s6. Multiply and rotate take one item per cycle unless the result stalls;
// a matrix item holds the output for four row transfers. Items with the unused mode code are
// taken and give no result.
// Reset (arst_n, asynchronous, active low) clears all stage valid bits and the row counter.
// Depends on qmu_pkg, qmu_stream_if, qmu_front, qmu_rot and qmu_rows.
module quaternion_math_unit_core #(
	parameter int FRAC_BITS = qmu_pkg::FRAC_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	qmu_stream_if.sink    item,
	qmu_stream_if.source  result
);

	qmu_pkg::stage_t    front_stage, rot_stage;
	qmu_pkg::in_item_t  in_data;
	qmu_pkg::out_item_t out_data;
	logic               rot_ready, done;

	assign in_data = item.data;

	qmu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_data   (in_data),
		.nxt_ready (rot_ready),
		.out_stage (front_stage)
	);

	qmu_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stage  (front_stage),
		.in_ready  (rot_ready),
		.done      (done),
		.out_stage (rot_stage)
	);

	qmu_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (rot_stage),
		.done      (done),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

	assign result.data = out_data;

endmodule

>>> tb/quaternion_math_unit_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for quaternion_math_unit_core: multiply, rotate and matrix-row items
// go in through a bursty driver; a stalling monitor checks each result in order.
// Depends on qmu_pkg, qmu_stream_if and the core itself.
module quaternion_math_unit_core_tb;

	typedef qmu_pkg::fix_t      fix_t;
	typedef qmu_pkg::in_item_t  in_item_t;
	typedef qmu_pkg::out_item_t out_item_t;

	localparam logic [1:0] M_MUL  = qmu_pkg::MODE_MUL;
	localparam logic [1:0] M_ROT  = qmu_pkg::MODE_ROT;
	localparam logic [1:0] M_MAT  = qmu_pkg::MODE_MAT;
	localparam logic [1:0] M_NONE = qmu_pkg::MODE_NONE;

	localparam int FRAC     = qmu_pkg::FRAC_BITS_DEF;
	localparam int N_RANDOM = 220;
	localparam int LIMIT    = 200000;
	localparam int DRAIN    = 20;

	typedef logic signed [127:0] wide_t;

	localparam wide_t FIX_MAX = 128'sd2147483647;
	localparam wide_t FIX_MIN = -128'sd2147483648;
	localparam fix_t  ONE     = fix_t'(1) <<< FRAC;

	logic clk = 1'b0;
	logic arst_n;

	qmu_stream_if #(.payload_t(in_item_t))  item_ch ();
	qmu_stream_if #(.payload_t(out_item_t)) result_ch ();

	quaternion_math_unit_core #(.FRAC_BITS(FRAC)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	in_item_t  stim_q[$];
	out_item_t res_want_q[$];
	out_item_t want_r;
	int        mode_cnt[4];
	int        n_checked;
	int        n_err;
	int        cycles;
	int        burst_left;
	int        gap_left;
	logic [15:0] stall_pat;

	function automatic wide_t mul(input fix_t a, input fix_t b);
		return wide_t'(a) * wide_t'(b);
	endfunction

	// floor shift, then clamp to 32 bits
	function automatic fix_t floor_sat(input wide_t acc);
		wide_t sh;
		sh = acc >>> FRAC;
		if (sh > FIX_MAX)
			return fix_t'(FIX_MAX[31:0]);
		else if (sh < FIX_MIN)
			return fix_t'(FIX_MIN[31:0]);
		return fix_t'(sh[31:0]);
	endfunction

	function automatic void push_row(input fix_t r0, input fix_t r1, input fix_t r2,
			input fix_t r3, input logic last);
		out_item_t r;
		r.res_0    = r0;
		r.res_1    = r1;
		r.res_2    = r2;
		r.res_3    = r3;
		r.last_row = last;
		res_want_q.push_back(r);
	endfunction

	function automatic void predict_results(input in_item_t it);
		fix_t  w, x, y, z, tx, ty, tz;
		wide_t one_w;
		w = it.q_w;
		x = it.q_x;
		y = it.q_y;
		z = it.q_z;
		one_w = wide_t'(ONE) <<< FRAC;
		case (it.mode)
			M_MUL: begin
				push_row(
					floor_sat(mul(w, it.p_w) - mul(x, it.p_x) - mul(y, it.p_y) - mul(z, it.p_z)),
					floor_sat(mul(w, it.p_x) + mul(x, it.p_w) + mul(y, it.p_z) - mul(z, it.p_y)),
					floor_sat(mul(w, it.p_y) - mul(x, it.p_z) + mul(y, it.p_w) + mul(z, it.p_x)),
					floor_sat(mul(w, it.p_z) + mul(x, it.p_y) - mul(y, it.p_x) + mul(z, it.p_w)),
					1'b1);
			end
			M_ROT: begin
				// t is clamped before the second cross product
				tx = floor_sat((mul(y, it.p_z) - mul(z, it.p_y)) <<< 1);
				ty = floor_sat((mul(z, it.p_x) - mul(x, it.p_z)) <<< 1);
				tz = floor_sat((mul(x, it.p_y) - mul(y, it.p_x)) <<< 1);
				push_row(
					floor_sat((wide_t'(it.p_x) <<< FRAC) + mul(w, tx) + mul(y, tz) - mul(z, ty)),
					floor_sat((wide_t'(it.p_y) <<< FRAC) + mul(w, ty) + mul(z, tx) - mul(x, tz)),
					floor_sat((wide_t'(it.p_z) <<< FRAC) + mul(w, tz) + mul(x, ty) - mul(y, tx)),
					'0, 1'b1);
			end
			M_MAT: begin
				push_row(floor_sat(one_w - ((mul(y, y) + mul(z, z)) <<< 1)),
					floor_sat((mul(x, y) + mul(w, z)) <<< 1),
					floor_sat((mul(x, z) - mul(w, y)) <<< 1), '0, 1'b0);
				push_row(floor_sat((mul(x, y) - mul(w, z)) <<< 1),
					floor_sat(one_w - ((mul(x, x) + mul(z, z)) <<< 1)),
					floor_sat((mul(y, z) + mul(w, x)) <<< 1), '0, 1'b0);
				push_row(floor_sat((mul(x, z) + mul(w, y)) <<< 1),
					floor_sat((mul(y, z) - mul(w, x)) <<< 1),
					floor_sat(one_w - ((mul(x, x) + mul(y, y)) <<< 1)), '0, 1'b0);
				push_row('0, '0, '0, ONE, 1'b1);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic in_item_t mk(input logic [1:0] m, input fix_t w, input fix_t x,
			input fix_t y, input fix_t z, input fix_t pw, input fix_t px, input fix_t py,
			input fix_t pz);
		in_item_t it;
		it.mode = m;
		it.q_w  = w;
		it.q_x  = x;
		it.q_y  = y;
		it.q_z  = z;
		it.p_w  = pw;
		it.p_x  = px;
		it.p_y  = py;
		it.p_z  = pz;
		return it;
	endfunction

	// unit-scale values most often, with full-range words, zero and the extremes mixed in
	function automatic fix_t rand_fix();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3, 4, 5: return fix_t'($urandom);
			default: return fix_t'(int'($urandom_range(0, 196608)) - 98304);
		endcase
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			n_err++;
		end
	endtask

	// driver: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data  <= '0;
			burst_left    <= 0;
			gap_left      <= 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				predict_results(item_ch.data);
				mode_cnt[item_ch.data.mode]++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left != 0) begin
					gap_left      <= gap_left - 1;
					item_ch.valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					item_ch.valid <= 1'b1;
					item_ch.data  <= stim_q.pop_front();
					if (burst_left == 0) begin
						burst_left <= $urandom_range(0, 12);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: ready follows a rotating stall pattern, reloaded now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_pat       <= 16'hffff;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (res_want_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p",
						$time, result_ch.data);
					n_err++;
				end else begin
					want_r = res_want_q.pop_front();
					cmp_field("res_0", want_r.res_0, result_ch.data.res_0);
					cmp_field("res_1", want_r.res_1, result_ch.data.res_1);
					cmp_field("res_2", want_r.res_2, result_ch.data.res_2);
					cmp_field("res_3", want_r.res_3, result_ch.data.res_3);
					cmp_field("last_row", 32'(want_r.last_row), 32'(result_ch.data.last_row));
					n_checked++;
				end
			end
			result_ch.ready <= stall_pat[0];
			if ($urandom_range(0, 39) == 0)
				stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
			else
				stall_pat <= {stall_pat[0], stall_pat[15:1]};
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, res_want_q.size());
			$display("quaternion_math_unit_core_tb: done, errors");
			$finish;
		end
	end

	initial begin : main
		int         n_rand;
		logic [1:0] m;
		fix_t       h;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		arst_n          = 1'b0;
		cycles          = 0;
		n_checked       = 0;
		n_err           = 0;
		mode_cnt        = '{default: 0};
		h               = 32'sd46341;

		// directed: identities, extremes, saturation and the unused mode code
		stim_q.push_back(mk(M_MUL, ONE, 0, 0, 0, 32'sh00012345, -32'sd70000, 32'sd3, -32'sd1));
		stim_q.push_back(mk(M_MUL, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(M_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		stim_q.push_back(mk(M_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		stim_q.push_back(mk(M_MUL, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		stim_q.push_back(mk(M_MUL, h, 0, 0, h, h, h, 0, 0));
		stim_q.push_back(mk(M_MUL, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1, 1, 1, 1));
		stim_q.push_back(mk(M_ROT, ONE, 0, 0, 0, 32'sh7fffffff, ONE, 2 * ONE, 3 * ONE));
		stim_q.push_back(mk(M_ROT, h, 0, 0, h, 0, ONE, 0, 0));
		stim_q.push_back(mk(M_ROT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		stim_q.push_back(mk(M_ROT, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		stim_q.push_back(mk(M_ROT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		stim_q.push_back(mk(M_ROT, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(M_ROT, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
			-32'sd1, -32'sd1));
		stim_q.push_back(mk(M_MAT, ONE, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(M_MAT, h, h, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(M_MAT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		stim_q.push_back(mk(M_MAT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
		stim_q.push_back(mk(M_MAT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			0, 0, 0, 0));
		stim_q.push_back(mk(M_NONE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		stim_q.push_back(mk(M_MUL, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
		stim_q.push_back(mk(M_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
		stim_q.push_back(mk(M_MAT, 0, 0, 0, 0, 0, 0, 0, 0));

		n_rand = 0;
		while (n_rand < N_RANDOM) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: m = M_MUL;
				4, 5, 6:    m = M_ROT;
				7, 8:       m = M_MAT;
				default:    m = M_NONE;
			endcase
			stim_q.push_back(mk(m, rand_fix(), rand_fix(), rand_fix(), rand_fix(),
				rand_fix(), rand_fix(), rand_fix(), rand_fix()));
			if (m != M_NONE)
				n_rand++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || item_ch.valid)
			@(posedge clk);
		while (res_want_q.size() != 0)
			@(posedge clk);
		// catch anything extra the pipe still emits
		repeat (DRAIN) @(posedge clk);

		if (res_want_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, res_want_q.size());
			n_err++;
		end
		$display("items: %0d multiply, %0d rotate, %0d matrix, %0d unused code",
			mode_cnt[M_MUL], mode_cnt[M_ROT], mode_cnt[M_MAT], mode_cnt[M_NONE]);
		$display("results checked: %0d, mismatches: %0d, cycles: %0d", n_checked, n_err, cycles);
		if (n_err == 0)
			$display("quaternion_math_unit_core_tb: done, clean");
		else
			$display("quaternion_math_unit_core_tb: done, errors");
		$finish;
	end

endmodule
